// ===== sv/sas_pkg.sv =====
package sas_pkg;

    // default configuration
    localparam int SAS_SLOTS       = 64;
    localparam int SAS_QUEUE_DEPTH = 2;

    // function codes on the input transaction
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // shape codes
    localparam logic [3:0] SHAPE_SQ8    = 4'd0;
    localparam logic [3:0] SHAPE_SQ16   = 4'd1;
    localparam logic [3:0] SHAPE_SQ32   = 4'd2;
    localparam logic [3:0] SHAPE_SQ64   = 4'd3;
    localparam logic [3:0] SHAPE_WD16   = 4'd4;
    localparam logic [3:0] SHAPE_WD32A  = 4'd5;
    localparam logic [3:0] SHAPE_WD32B  = 4'd6;
    localparam logic [3:0] SHAPE_WD64   = 4'd7;
    localparam logic [3:0] SHAPE_TL16   = 4'd8;
    localparam logic [3:0] SHAPE_TL32A  = 4'd9;
    localparam logic [3:0] SHAPE_TL32B  = 4'd10;
    localparam logic [3:0] SHAPE_TL64   = 4'd11;

    // classified command kinds passed from front to back
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] bank;
        logic [3:0] shape;
        logic [3:0] last_frame;
        logic [3:0] speed;
    } cmd_t;

    // one slot entry of the slot memory
    typedef struct packed {
        logic [3:0] counter;
        logic [3:0] period;
        logic [3:0] cur_frame;
        logic [3:0] last_frame;
        logic [3:0] shape;
    } slot_word_t;

    // one frame reload event
    typedef struct packed {
        logic [12:0] word_offset;
        logic [3:0]  shape;
        logic [3:0]  frame;
        logic [5:0]  slot;
    } event_t;

    // frame times frame size in words; all sizes are powers of two
    function automatic logic [12:0] frame_word_offset(input logic [3:0] frame,
                                                      input logic [3:0] shape);
        logic [3:0] sh;
        logic       ok;
        ok = 1'b1;
        sh = 4'd0;
        unique case (shape)
            SHAPE_SQ8:   sh = 4'd3;
            SHAPE_SQ16:  sh = 4'd5;
            SHAPE_SQ32:  sh = 4'd7;
            SHAPE_SQ64:  sh = 4'd9;
            SHAPE_WD16:  sh = 4'd4;
            SHAPE_WD32A: sh = 4'd5;
            SHAPE_WD32B: sh = 4'd6;
            SHAPE_WD64:  sh = 4'd8;
            SHAPE_TL16:  sh = 4'd4;
            SHAPE_TL32A: sh = 4'd5;
            SHAPE_TL32B: sh = 4'd6;
            SHAPE_TL64:  sh = 4'd8;
            default:     ok = 1'b0;
        endcase
        return ok ? (13'(frame) << sh) : 13'd0;
    endfunction

endpackage

// ===== sv/sas_front.sv =====
module sas_front
    import sas_pkg::*;
#(
    parameter int SLOTS = SAS_SLOTS
) (
    input  logic        s_tvalid,
    input  logic [1:0]  s_func,
    input  logic [5:0]  s_bank,
    input  logic [3:0]  s_shape,
    input  logic [4:0]  s_frame_count,
    input  logic [3:0]  s_speed,
    input  logic        q_full,
    output logic        s_tready,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic       keep;
    logic [4:0] cnt_m1;

    // accept whenever the queue has room; unused codes are dropped
    assign s_tready = !q_full;

    // last frame is frame_count - 1 mod 16, zero count acts as one
    assign cnt_m1 = s_frame_count - 5'd1;

    // classify the transaction
    always_comb begin
        keep             = 1'b0;
        q_cmd.op         = OP_TICK;
        q_cmd.last_frame = (s_frame_count == 5'd0) ? 4'd0 : cnt_m1[3:0];
        q_cmd.bank       = s_bank;
        q_cmd.shape      = s_shape;
        q_cmd.speed      = s_speed;
        unique case (s_func)
            FUNC_TICK: begin
                keep     = 1'b1;
                q_cmd.op = OP_TICK;
            end
            FUNC_START: begin
                keep     = (32'(s_bank) < SLOTS);
                q_cmd.op = OP_START;
            end
            FUNC_STOP: begin
                keep     = (32'(s_bank) < SLOTS);
                q_cmd.op = OP_STOP;
            end
            default: keep = 1'b0;
        endcase
    end

    assign q_push = s_tvalid && s_tready && keep;

endmodule

// ===== sv/sas_queue.sv =====
module sas_queue
    import sas_pkg::*;
#(
    parameter int DEPTH = SAS_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_vld,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_vld = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && head_vld;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/sas_back.sv =====
module sas_back
    import sas_pkg::*;
#(
    parameter int SLOTS = SAS_SLOTS
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_vld,
    input  cmd_t   q_cmd,
    output logic   q_pop,
    output logic   out_vld,
    output event_t out_evt,
    output logic   out_last,
    input  logic   out_ready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] a_idx_reg, a_idx_next;
    logic             b_vld_reg, b_vld_next;
    logic [IDX_W-1:0] b_idx_reg;
    slot_word_t       rd_data_reg;
    logic [SLOTS-1:0] active_reg, active_next;
    logic             hold_vld_reg, hold_vld_next;
    event_t           hold_reg, hold_next;
    logic             out_vld_reg, out_vld_next;
    event_t           out_evt_reg;
    logic             out_last_reg;

    slot_word_t       mem [SLOTS];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_word_t       mem_wdata;
    logic             rd_en;

    logic             out_free, advance, load_out, load_last;
    logic             b_active, b_emit;
    logic [3:0]       b_dec, b_inc, b_frame;
    logic [IDX_W-1:0] cmd_idx;
    event_t           b_evt;

    assign out_vld  = out_vld_reg;
    assign out_evt  = out_evt_reg;
    assign out_last = out_last_reg;

    assign cmd_idx  = IDX_W'(q_cmd.bank);
    assign out_free = !out_vld_reg || out_ready;

    // slot update at stage b
    assign b_active = active_reg[b_idx_reg];
    assign b_dec    = rd_data_reg.counter - 4'd1;
    assign b_emit   = b_vld_reg && b_active && (b_dec == 4'd0);
    assign b_inc    = rd_data_reg.cur_frame + 4'd1;
    assign b_frame  = (b_inc > rd_data_reg.last_frame) ? 4'd0 : b_inc;

    assign b_evt.slot        = 6'(b_idx_reg);
    assign b_evt.frame       = b_frame;
    assign b_evt.shape       = rd_data_reg.shape;
    assign b_evt.word_offset = frame_word_offset(b_frame, rd_data_reg.shape);

    // walk stalls only when a new event finds hold and output both taken
    assign advance = !(b_emit && hold_vld_reg && !out_free);

    // sequencer and event staging
    always_comb begin
        state_next    = state_reg;
        a_idx_next    = a_idx_reg;
        b_vld_next    = b_vld_reg;
        active_next   = active_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = b_idx_reg;
        mem_wdata     = rd_data_reg;
        load_out      = 1'b0;
        load_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_vld) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_START: begin
                            mem_we                = 1'b1;
                            mem_waddr             = cmd_idx;
                            mem_wdata.counter     = q_cmd.speed;
                            mem_wdata.period      = q_cmd.speed;
                            mem_wdata.cur_frame   = q_cmd.last_frame;
                            mem_wdata.last_frame  = q_cmd.last_frame;
                            mem_wdata.shape       = q_cmd.shape;
                            active_next[cmd_idx]  = 1'b1;
                        end
                        OP_STOP: begin
                            active_next[cmd_idx] = 1'b0;
                        end
                        OP_TICK: begin
                            a_idx_next = '0;
                            state_next = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (advance) begin
                    rd_en      = 1'b1;
                    b_vld_next = 1'b1;
                    a_idx_next = a_idx_reg + 1'b1;
                    if (a_idx_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (advance) begin
                    b_vld_next = 1'b0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!hold_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load_out      = 1'b1;
                    load_last     = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // write back the processed slot and stage its event
        if (b_vld_reg && advance && b_active) begin
            mem_we              = 1'b1;
            mem_waddr           = b_idx_reg;
            mem_wdata.counter   = b_emit ? rd_data_reg.period : b_dec;
            mem_wdata.cur_frame = b_emit ? b_frame : rd_data_reg.cur_frame;
            if (b_emit) begin
                if (hold_vld_reg) begin
                    load_out = 1'b1;
                end
                hold_next     = b_evt;
                hold_vld_next = 1'b1;
            end
        end

        // output register
        if (load_out) begin
            out_vld_next = 1'b1;
        end else if (out_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            a_idx_reg    <= '0;
            b_vld_reg    <= 1'b0;
            active_reg   <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            a_idx_reg    <= a_idx_next;
            b_vld_reg    <= b_vld_next;
            active_reg   <= active_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        if (rd_en) begin
            b_idx_reg <= a_idx_reg;
        end
        if (load_out) begin
            out_evt_reg  <= hold_reg;
            out_last_reg <= load_last;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[a_idx_reg];
        end
    end

endmodule

// ===== sv/sprite_animation_sequencer.sv =====
// start and stop pass the command queue and take effect when the back end pops them
// tick: one slot per cycle from the slot memory read port while the walk is not
// stalled by the output; the final event of a tick leaves after the walk ends
// ticks do not overlap; start or stop taken one per cycle while no tick is in progress
// reset: synchronous active low, clears active flags, command queue and
// output; slot memory entries keep their contents and are rewritten on start
module sprite_animation_sequencer
    import sas_pkg::*;
#(
    parameter int SLOTS       = SAS_SLOTS,
    parameter int QUEUE_DEPTH = SAS_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // bank[5:0], shape[9:6], frame_count[14:10], speed[18:15]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // slot[5:0], frame[9:6], sprite_shape[13:10],
                                  // word_offset[26:14]
    output logic        m_tlast
);

    logic   q_push, q_pop, q_full, q_vld;
    cmd_t   push_cmd, head_cmd;
    event_t out_evt;

    // front: accept and classify
    sas_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_func       (s_tuser),
        .s_bank       (s_tdata[5:0]),
        .s_shape      (s_tdata[9:6]),
        .s_frame_count(s_tdata[14:10]),
        .s_speed      (s_tdata[18:15]),
        .q_full       (q_full),
        .s_tready     (s_tready),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    // command queue between front and back
    sas_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .pop     (q_pop),
        .full    (q_full),
        .head_vld(q_vld),
        .head_cmd(head_cmd)
    );

    // back: slot table and tick walk
    sas_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_vld    (q_vld),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .out_vld  (m_tvalid),
        .out_evt  (out_evt),
        .out_last (m_tlast),
        .out_ready(m_tready)
    );

    assign m_tdata = {5'd0, out_evt.word_offset, out_evt.shape, out_evt.frame, out_evt.slot};

endmodule

// ===== sv/sas_checker.sv =====
module sas_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // frame zero always maps to offset zero
    a_frame0_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:6] == 4'd0 |-> m_tdata[26:14] == 13'd0)
        else $error("nonzero offset for frame zero");

    // shape codes without a size give offset zero
    a_bad_shape_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13:12] == 2'b11 |-> m_tdata[26:14] == 13'd0)
        else $error("nonzero offset for unsized shape");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:27] == 5'd0)
        else $error("padding bits set");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
